// ===== design/glf_pkg.sv =====
// Package for the grid line finder: sizes, constants and the result record.
// Used by glf_track, glf_outq and grid_line_finder_core.
`default_nettype none
package glf_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int IDX_W       = $clog2(MAX_LEN + 1);
  localparam int POS_W       = 14;
  localparam int RUN_W       = 8;
  localparam int CFG_W       = 8;
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

  localparam logic [RUN_W-1:0] RUN_MAX      = {RUN_W{1'b1}};
  localparam logic [CFG_W-1:0] MIN_RUN_RST  = CFG_W'(4);
  localparam logic [IDX_W-1:0] MAX_LEN_IDX  = IDX_W'(MAX_LEN);
  localparam logic [IDX_W-1:0] LOOKAHEAD    = IDX_W'(2);

  typedef struct packed {
    logic signed [POS_W-1:0] line_position;
    logic                    no_spot_error;
    logic                    final_line;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage
`default_nettype wire

// ===== design/glf_track.sv =====
// Per-sample spot tracker: lookahead window, run counter and line marks.
// Emits up to two results per transfer. Depends on glf_pkg.
`default_nettype none
module glf_track (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire [glf_pkg::CFG_W-1:0] cfg_wdata,
  input  wire                     in_fire,
  input  wire                     sample_high,
  input  wire                     last_sample,
  output glf_pkg::push_t          push
);
  import glf_pkg::*;

  logic [1:0]       win_r, win_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ins_r, ins_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic [IDX_W-1:0] mark_r, mark_nxt;
  logic             is_end_r, is_end_nxt;
  logic             seen_r, seen_nxt;
  logic [CFG_W-1:0] min_run_r;

  logic             active, eval, open_spot;
  logic [IDX_W-1:0] pos;
  logic [IDX_W:0]   mid_sum;
  logic [POS_W-1:0] line;
  logic             ins1;
  logic [RUN_W-1:0] run1;
  logic [IDX_W-1:0] mark1;

  always_comb begin
    active    = idx_r < MAX_LEN_IDX;
    eval      = active && (idx_r >= LOOKAHEAD);
    pos       = idx_r - LOOKAHEAD;
    open_spot = eval && !ins_r && win_r[1] && win_r[0] && sample_high;
    mid_sum   = {1'b0, mark_r} + {1'b0, pos};
    line      = is_end_r ? POS_W'(mid_sum >> 1) : POS_W'(pos) - POS_W'(1);

    ins1  = ins_r | open_spot;
    run1  = open_spot ? '0 : run_r;
    mark1 = open_spot ? pos : mark_r;

    ins_nxt    = ins1;
    run_nxt    = run1;
    mark_nxt   = mark1;
    is_end_nxt = open_spot ? 1'b0 : is_end_r;
    seen_nxt   = seen_r | open_spot;
    if (eval && ins1) begin
      if (run1 < RUN_MAX) begin
        run_nxt = run1 + RUN_W'(1);
      end
      if (!win_r[0] && (run_nxt > RUN_W'(min_run_r))) begin
        ins_nxt    = 1'b0;
        mark_nxt   = pos;
        is_end_nxt = 1'b1;
      end
    end
    win_nxt = win_r;
    idx_nxt = idx_r;
    if (active) begin
      win_nxt = {win_r[0], sample_high};
      idx_nxt = idx_r + IDX_W'(1);
    end

    push.res0.line_position = line;
    push.res0.no_spot_error = 1'b0;
    push.res0.final_line    = 1'b0;
    push.res1.line_position = seen_nxt ? POS_W'(mark_nxt) + POS_W'(1) : '0;
    push.res1.no_spot_error = !seen_nxt;
    push.res1.final_line    = 1'b1;
    push.push0 = 1'b0;
    push.push1 = 1'b0;
    if (in_fire) begin
      if (open_spot) begin
        push.push0 = 1'b1;
        push.push1 = last_sample;
      end else if (last_sample) begin
        push.push0 = 1'b1;
        push.res0  = push.res1;
      end
    end

    if (last_sample) begin
      win_nxt    = '0;
      idx_nxt    = '0;
      ins_nxt    = 1'b0;
      run_nxt    = '0;
      mark_nxt   = '0;
      is_end_nxt = 1'b0;
      seen_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      idx_r     <= '0;
      ins_r     <= 1'b0;
      run_r     <= '0;
      mark_r    <= '0;
      is_end_r  <= 1'b0;
      seen_r    <= 1'b0;
      min_run_r <= MIN_RUN_RST;
    end else begin
      if (cfg_we) begin
        min_run_r <= cfg_wdata;
      end
      if (in_fire) begin
        win_r    <= win_nxt;
        idx_r    <= idx_nxt;
        ins_r    <= ins_nxt;
        run_r    <= run_nxt;
        mark_r   <= mark_nxt;
        is_end_r <= is_end_nxt;
        seen_r   <= seen_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/glf_outq.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on glf_pkg.
`default_nettype none
module glf_outq (
  input  wire              clk,
  input  wire              rst_n,
  input  glf_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  wire              out_ready,
  output glf_pkg::result_t out_res
);
  import glf_pkg::*;

  result_t               buf_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wptr_r, wptr_nxt, rptr_r;
  logic [OQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  pop;
  logic [OQ_PTR_W-1:0]   wptr1;

  always_comb begin
    out_valid = cnt_r != '0;
    out_res   = buf_r[rptr_r];
    room      = cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2);
    pop       = out_valid && out_ready;
    wptr1     = wptr_r + OQ_PTR_W'(1);
    wptr_nxt  = wptr_r + OQ_PTR_W'(push.push0) + OQ_PTR_W'(push.push1);
    cnt_nxt   = cnt_r + OQ_CNT_W'(push.push0) + OQ_CNT_W'(push.push1)
                - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      buf_r[wptr_r] <= push.res0;
    end
    if (push.push1) begin
      buf_r[wptr1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      cnt_r  <= cnt_nxt;
      if (pop) begin
        rptr_r <= rptr_r + OQ_PTR_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/grid_line_finder_core.sv =====
// Top level of the grid line finder: tracker plus result queue.
// Depends on glf_pkg, glf_track and glf_outq.
//
// One projection sample is taken per cycle while in_ready is high. The tracker
// updates its state in the cycle of the transfer and writes zero, one or two
// results into a four-entry queue; results leave one per cycle while out_ready
// is high. in_ready is low while the queue holds more than two results. Two
// results come only from a spot start on the last sample, and a following
// signal gives no result on its first two samples unless it ends there, so
// with out_ready held high the queue never passes two entries and samples are
// taken at one per cycle; the input stalls only while the receiver holds off.
// A result is registered into the queue before it appears at the outputs.
`default_nettype none
module grid_line_finder_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire [glf_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_sample_high,
  input  wire                        in_last_sample,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic signed [glf_pkg::POS_W-1:0] out_line_position,
  output logic                       out_no_spot_error,
  output logic                       out_final_line
);
  import glf_pkg::*;

  push_t   push;
  result_t res;
  logic    room;
  logic    in_fire;

  assign in_ready = room;
  assign in_fire  = in_valid && room;

  glf_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_fire    (in_fire),
    .sample_high(in_sample_high),
    .last_sample(in_last_sample),
    .push       (push)
  );

  glf_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign out_line_position = res.line_position;
  assign out_no_spot_error = res.no_spot_error;
  assign out_final_line    = res.final_line;

endmodule
`default_nettype wire
